[rtl/fmv_pkg.sv]
`default_nettype none

package fmv_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int ENTRY_BYTES  = 11;
  localparam int MAX_FIELDS   = 256;
  localparam int MAX_RECORDS  = 16384;

  localparam int HS_DEPTH = 16;
  localparam int HS_IDX_W = $clog2(HS_DEPTH);
  localparam int POS_W    = $clog2(HEADER_BYTES + 1);
  localparam int EP_W     = $clog2(ENTRY_BYTES);
  localparam int REGION_W = 16 + $clog2(ENTRY_BYTES + 1) + 1;

  localparam int CODE_LEN  = 6;
  localparam int OFF_FIRST = 7;
  localparam int OFF_LAST  = 10;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_VERSION     = 4'd2,
    ST_NO_RECORDS  = 4'd3,
    ST_ENTRY_SIZE  = 4'd4,
    ST_RECORD_SIZE = 4'd5,
    ST_FIELDS      = 4'd6,
    ST_RECORDS     = 4'd7,
    ST_INDEX_END   = 4'd8,
    ST_OFFSET      = 4'd9,
    ST_CODE        = 4'd10,
    ST_TRUNCATED   = 4'd11
  } status_t;

  typedef logic [HS_DEPTH-1:0][7:0] hdr_bytes_t;

  typedef struct packed {
    status_t               status;
    logic [15:0]           version;
    logic [31:0]           date;
    logic [15:0]           count;
    logic [31:0]           rec_size;
    logic [29:0]           fields;
    logic [REGION_W-1:0]   region;
  } hdr_eval_t;

endpackage

`default_nettype wire

[rtl/fmv_in_if.sv]
`default_nettype none

interface fmv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  member_byte;
  logic [31:0] member_length;
  logic        final_byte;

  modport source (output valid, output member_byte, output member_length,
                  output final_byte, input ready);
  modport sink (input valid, input member_byte, input member_length,
                input final_byte, output ready);
endinterface

`default_nettype wire

[rtl/fmv_out_if.sv]
`default_nettype none

interface fmv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [15:0] version_seen;
  logic [31:0] report_date_seen;
  logic [15:0] records_declared;
  logic [29:0] fields_per_record;
  logic [31:0] data_region_start;
  logic [15:0] failing_entry;

  modport source (output valid, output status, output version_seen,
                  output report_date_seen, output records_declared,
                  output fields_per_record, output data_region_start,
                  output failing_entry, input ready);
  modport sink (input valid, input status, input version_seen,
                input report_date_seen, input records_declared,
                input fields_per_record, input data_region_start,
                input failing_entry, output ready);
endinterface

`default_nettype wire

[rtl/fmv_hdr_eval.sv]
`default_nettype none

module fmv_hdr_eval (
  input  fmv_pkg::hdr_bytes_t hdr,
  input  logic [31:0]         member_length,
  output fmv_pkg::hdr_eval_t  ev
);
  import fmv_pkg::*;

  logic [15:0]         esize;
  logic [REGION_W-1:0] region;

  always_comb begin
    ev.version  = {hdr[1], hdr[0]};
    ev.date     = {hdr[5], hdr[4], hdr[3], hdr[2]};
    ev.count    = {hdr[7], hdr[6]};
    esize       = {hdr[11], hdr[10]};
    ev.rec_size = {hdr[15], hdr[14], hdr[13], hdr[12]};
    ev.fields   = ev.rec_size[31:2];
    region      = REGION_W'(HEADER_BYTES)
                + REGION_W'(ev.count) * REGION_W'(ENTRY_BYTES);
    ev.region   = region;

    // checks in priority order, first failure wins
    if (ev.version != 16'd1) begin
      ev.status = ST_VERSION;
    end else if (ev.count == 16'd0) begin
      ev.status = ST_NO_RECORDS;
    end else if (esize != 16'(ENTRY_BYTES)) begin
      ev.status = ST_ENTRY_SIZE;
    end else if (ev.rec_size == 32'd0 || ev.rec_size[1:0] != 2'd0) begin
      ev.status = ST_RECORD_SIZE;
    end else if (ev.fields > 30'(MAX_FIELDS)) begin
      ev.status = ST_FIELDS;
    end else if (ev.count > 16'(MAX_RECORDS)) begin
      ev.status = ST_RECORDS;
    end else if (32'(region) > member_length) begin
      ev.status = ST_INDEX_END;
    end else begin
      ev.status = ST_OK;
    end
  end

endmodule

`default_nettype wire

[rtl/finance_member_validator.sv]
// an accepted byte passes through the input register, then its status is set on the output register
// throughput: one byte per cycle while the output side is ready, with at most one status per member
// the input register and the output register each hold one transaction
// reset (rst_n low, synchronous) empties both registers and re-arms the parser
// header byte storage is not cleared by reset and is refilled by every member that is not short
`default_nettype none

module finance_member_validator (
  input  logic     clk,
  input  logic     rst_n,
  fmv_in_if.sink   in_item,
  fmv_out_if.source out_item
);
  import fmv_pkg::*;

  localparam int HDR_LAST = HEADER_BYTES - 1;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic [31:0] s1_len_r;
  logic        s1_fin_r;

  // parser state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [EP_W-1:0]     ep_r, ep_nxt;
  logic [15:0]         en_r, en_nxt;
  logic [23:0]         og_r, og_nxt;
  logic                digits_r, digits_nxt;
  logic [REGION_W-1:0] iend_r, iend_nxt;
  logic                decided_r, decided_nxt;
  hdr_bytes_t          hs_r, hs_nxt;

  // output register
  logic        out_valid_r;
  status_t     o_status_r;
  logic [15:0] o_version_r;
  logic [31:0] o_date_r;
  logic [15:0] o_count_r;
  logic [29:0] o_fields_r;
  logic [31:0] o_region_r;
  logic [15:0] o_fail_r;

  logic        go;
  logic        at_hdr, hdr_last, is_short;
  logic        emit, have_hdr;
  status_t     st;
  logic [15:0] fail_ent;
  logic [31:0] off;
  logic        off_bad, last_entry, not_digit;
  hdr_bytes_t  hdr_view;
  hdr_eval_t   ev;

  assign go           = s1_valid_r && (!out_valid_r || out_item.ready);
  assign in_item.ready = !s1_valid_r || go;

  assign at_hdr   = pos_r < POS_W'(HEADER_BYTES);
  assign hdr_last = pos_r == POS_W'(HDR_LAST);
  assign is_short = (pos_r == '0) && (s1_len_r < 32'(HEADER_BYTES));

  // header as seen once the current byte is stored
  always_comb begin
    hdr_view = hs_r;
    if (HDR_LAST < HS_DEPTH && hdr_last) begin
      hdr_view[HS_IDX_W'(HDR_LAST)] = s1_byte_r;
    end
  end

  fmv_hdr_eval u_hdr_eval (
    .hdr           (hdr_view),
    .member_length (s1_len_r),
    .ev            (ev)
  );

  assign off        = {s1_byte_r, og_r};
  assign off_bad    = (off < 32'(iend_r)) || (off > s1_len_r)
                   || (ev.rec_size > (s1_len_r - off));
  assign last_entry = (17'(en_r) + 17'd1) >= 17'(ev.count);
  assign not_digit  = (s1_byte_r < CH_ZERO) || (s1_byte_r > CH_NINE);

  always_comb begin
    pos_nxt     = pos_r;
    ep_nxt      = ep_r;
    en_nxt      = en_r;
    og_nxt      = og_r;
    digits_nxt  = digits_r;
    iend_nxt    = iend_r;
    decided_nxt = decided_r;
    hs_nxt      = hs_r;
    emit        = 1'b0;
    have_hdr    = 1'b0;
    st          = ST_OK;
    fail_ent    = '0;
    if (go) begin
      if (!decided_r) begin
        if (is_short) begin
          emit = 1'b1;
          st   = ST_SHORT;
        end else if (at_hdr) begin
          if (pos_r < POS_W'(HS_DEPTH)) begin
            hs_nxt[pos_r[HS_IDX_W-1:0]] = s1_byte_r;
          end
          if (hdr_last) begin
            have_hdr = 1'b1;
            if (ev.status != ST_OK) begin
              emit = 1'b1;
              st   = ev.status;
            end else begin
              iend_nxt = ev.region;
            end
          end
        end else begin
          have_hdr = 1'b1;
          if (ep_r < EP_W'(CODE_LEN) && not_digit) begin
            digits_nxt = 1'b0;
          end
          if (ep_r == EP_W'(OFF_FIRST)) begin
            og_nxt[7:0] = s1_byte_r;
          end
          if (ep_r == EP_W'(OFF_FIRST + 1)) begin
            og_nxt[15:8] = s1_byte_r;
          end
          if (ep_r == EP_W'(OFF_FIRST + 2)) begin
            og_nxt[23:16] = s1_byte_r;
          end
          if (ep_r == EP_W'(OFF_LAST)) begin
            if (off_bad) begin
              emit     = 1'b1;
              st       = ST_OFFSET;
              fail_ent = en_r;
            end else if (!digits_r) begin
              emit     = 1'b1;
              st       = ST_CODE;
              fail_ent = en_r;
            end else if (last_entry) begin
              emit = 1'b1;
              st   = ST_OK;
            end
          end
          if (ep_r == EP_W'(ENTRY_BYTES - 1)) begin
            ep_nxt     = '0;
            en_nxt     = en_r + 16'd1;
            og_nxt     = '0;
            digits_nxt = 1'b1;
          end else begin
            ep_nxt = ep_r + EP_W'(1);
          end
        end
        if (!emit && s1_fin_r) begin
          emit = 1'b1;
          st   = ST_TRUNCATED;
        end
        if (emit) begin
          decided_nxt = 1'b1;
        end
        if (at_hdr) begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      if (s1_fin_r) begin
        pos_nxt     = '0;
        ep_nxt      = '0;
        en_nxt      = '0;
        og_nxt      = '0;
        digits_nxt  = 1'b1;
        iend_nxt    = '0;
        decided_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      ep_r        <= '0;
      en_r        <= '0;
      og_r        <= '0;
      digits_r    <= 1'b1;
      iend_r      <= '0;
      decided_r   <= 1'b0;
    end else begin
      if (in_item.ready) begin
        s1_valid_r <= in_item.valid;
      end
      if (go) begin
        out_valid_r <= emit;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
      pos_r     <= pos_nxt;
      ep_r      <= ep_nxt;
      en_r      <= en_nxt;
      og_r      <= og_nxt;
      digits_r  <= digits_nxt;
      iend_r    <= iend_nxt;
      decided_r <= decided_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hs_r <= hs_nxt;
    if (in_item.valid && in_item.ready) begin
      s1_byte_r <= in_item.member_byte;
      s1_len_r  <= in_item.member_length;
      s1_fin_r  <= in_item.final_byte;
    end
    if (go && emit) begin
      o_status_r <= st;
      o_fail_r   <= fail_ent;
      if (have_hdr) begin
        o_version_r <= ev.version;
        o_date_r    <= ev.date;
        o_count_r   <= ev.count;
        o_fields_r  <= ev.fields;
        o_region_r  <= 32'(ev.region);
      end else begin
        o_version_r <= '0;
        o_date_r    <= '0;
        o_count_r   <= '0;
        o_fields_r  <= '0;
        o_region_r  <= '0;
      end
    end
  end

  assign out_item.valid             = out_valid_r;
  assign out_item.status            = o_status_r;
  assign out_item.version_seen      = o_version_r;
  assign out_item.report_date_seen  = o_date_r;
  assign out_item.records_declared  = o_count_r;
  assign out_item.fields_per_record = o_fields_r;
  assign out_item.data_region_start = o_region_r;
  assign out_item.failing_entry     = o_fail_r;

  a_fin_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    go && s1_fin_r |=> !decided_r && pos_r == '0 && ep_r == '0 && en_r == '0)
    else $error("final byte did not re-arm the parser");

  a_fail_entry_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_fail_r != '0 |-> (o_status_r == ST_OFFSET || o_status_r == ST_CODE))
    else $error("failing entry set on a status that is not an entry failure");

  a_short_no_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_status_r == ST_SHORT
      |-> o_version_r == '0 && o_count_r == '0 && o_region_r == '0)
    else $error("short member reported with header fields");

  a_ok_header_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_status_r == ST_OK |-> o_version_r == 16'd1 && o_count_r != '0)
    else $error("ok status with a header that should have failed");

  a_entry_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ep_r} < (EP_W + 1)'(ENTRY_BYTES))
    else $error("entry byte position out of range");

endmodule

`default_nettype wire

[sim/testbench.sv]
`default_nettype none

module testbench;
  import fmv_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [15:0] version;
    logic [31:0] date;
    logic [15:0] count;
    logic [29:0] fields;
    logic [31:0] region;
    logic [15:0] entry;
  } verdict_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_LOW,
    FLAW_NO_ROOM,
    FLAW_PAST_LEN,
    FLAW_TOP,
    FLAW_CODE
  } flaw_t;

  typedef struct {
    logic [15:0] ver;
    logic [31:0] date;
    logic [15:0] cnt;
    logic [15:0] esz;
    logic [31:0] rsz;
    logic [31:0] len;
    int          cut;
    flaw_t       flaw;
    int          flaw_at;
    int          extra;
    bit          typed;
    status_t     want;
  } plan_t;

  logic clk = 1'b0;
  logic rst_n;

  fmv_in_if  member_in ();
  fmv_out_if status_out ();

  finance_member_validator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (member_in),
    .out_item (status_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  hdr_store [HEADER_BYTES];
  logic [31:0] byte_at;
  logic [5:0]  slot;
  logic [15:0] entry_idx;
  logic [31:0] offset_acc;
  bit          code_digits;
  logic [31:0] index_top;
  bit          settled;

  verdict_t verdicts_due [$];
  int       mismatches = 0;
  int       live_bytes = 0;
  int       idle_pct = 23;

  // header and truncation cases, then entry defects, then one member checked by the predictor alone
  plan_t plan_rows [$] = '{
    '{16'd1, 32'h0, 16'd1, 16'd11, 32'd4, 32'd0, 1, FLAW_NONE, 0, 0, 1'b1, ST_SHORT},
    '{16'd1, 32'hFFFF_FFFF, 16'd1, 16'd11, 32'd4, 32'd15, 3, FLAW_NONE, 0, 2, 1'b1, ST_SHORT},
    '{16'd0, 32'h0, 16'd1, 16'd11, 32'd4, 32'd16, 16, FLAW_NONE, 0, 0, 1'b1, ST_VERSION},
    '{16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16,
      FLAW_NONE, 0, 3, 1'b1, ST_VERSION},
    '{16'd1, 32'h1234_5678, 16'd0, 16'd11, 32'd4, 32'd100, 16, FLAW_NONE, 0, 0, 1'b1,
      ST_NO_RECORDS},
    '{16'd1, 32'h0202_0101, 16'd1, 16'd10, 32'd4, 32'd100, 16, FLAW_NONE, 0, 0, 1'b1,
      ST_ENTRY_SIZE},
    '{16'd1, 32'hA5A5_5A5A, 16'd1, 16'hFFFF, 32'd4, 32'd100, 16, FLAW_NONE, 0, 0, 1'b1,
      ST_ENTRY_SIZE},
    '{16'd1, 32'h0, 16'd1, 16'd11, 32'd0, 32'd100, 16, FLAW_NONE, 0, 0, 1'b1, ST_RECORD_SIZE},
    '{16'd1, 32'h0, 16'd1, 16'd11, 32'd6, 32'd100, 16, FLAW_NONE, 0, 0, 1'b1, ST_RECORD_SIZE},
    '{16'd1, 32'h0, 16'd1, 16'd11, 32'd1028, 32'd100, 16, FLAW_NONE, 0, 0, 1'b1, ST_FIELDS},
    '{16'd1, 32'h0, 16'd1, 16'd11, 32'hFFFF_FFFC, 32'd100, 16, FLAW_NONE, 0, 0, 1'b1,
      ST_FIELDS},
    '{16'd1, 32'h0, 16'd16385, 16'd11, 32'd4, 32'hFFFF_FFFF, 16, FLAW_NONE, 0, 0, 1'b1,
      ST_RECORDS},
    '{16'd1, 32'h0, 16'hFFFF, 16'd11, 32'd1024, 32'hFFFF_FFFF, 16, FLAW_NONE, 0, 0, 1'b1,
      ST_RECORDS},
    '{16'd1, 32'h0, 16'd2, 16'd11, 32'd4, 32'd37, 16, FLAW_NONE, 0, 0, 1'b1, ST_INDEX_END},
    '{16'd1, 32'h8000_0001, 16'd16384, 16'd11, 32'd1024, 32'hFFFF_FFFF, 38, FLAW_NONE, 0, 0,
      1'b1, ST_TRUNCATED},
    '{16'd1, 32'h0, 16'd1, 16'd11, 32'd4, 32'd100, 10, FLAW_NONE, 0, 0, 1'b1, ST_TRUNCATED},
    '{16'd1, 32'h7FFF_FFFF, 16'd1, 16'd11, 32'd4, 32'd100, 16, FLAW_NONE, 0, 0, 1'b1,
      ST_TRUNCATED},
    '{16'd1, 32'h2024_0101, 16'd1, 16'd11, 32'd4, 32'd31, 0, FLAW_NONE, 0, 0, 1'b1, ST_OK},
    '{16'd1, 32'hFFFF_0000, 16'd2, 16'd11, 32'd1024, 32'hFFFF_FFFF, 0, FLAW_TOP, 1, 2, 1'b1,
      ST_OK},
    '{16'd1, 32'h0, 16'd3, 16'd11, 32'd8, 32'd500, 0, FLAW_LOW, 1, 0, 1'b1, ST_OFFSET},
    '{16'd1, 32'h0, 16'd3, 16'd11, 32'd8, 32'd500, 0, FLAW_NO_ROOM, 2, 0, 1'b1, ST_OFFSET},
    '{16'd1, 32'h0, 16'd2, 16'd11, 32'd8, 32'd500, 0, FLAW_PAST_LEN, 0, 0, 1'b1, ST_OFFSET},
    '{16'd1, 32'h0, 16'd4, 16'd11, 32'd8, 32'd500, 0, FLAW_CODE, 3, 0, 1'b1, ST_CODE},
    '{16'd1, 32'h5555_AAAA, 16'd4, 16'd11, 32'd1024, 32'd5000, 0, FLAW_NONE, 0, 0, 1'b0,
      ST_OK}
  };

  function automatic logic [31:0] hdr_word(int at, int n);
    logic [31:0] w;
    int i;
    w = '0;
    for (i = n - 1; i >= 0; i--) w = (w << 8) | 32'(hdr_store[at + i]);
    return w;
  endfunction

  function automatic logic [31:0] index_span(logic [15:0] cnt);
    return 32'(HEADER_BYTES) + 32'(cnt) * 32'(ENTRY_BYTES);
  endfunction

  function automatic status_t header_verdict(logic [31:0] len);
    logic [31:0] rsz;
    logic [15:0] cnt;
    rsz = hdr_word(12, 4);
    cnt = 16'(hdr_word(6, 2));
    if (hdr_word(0, 2) != 32'd1) return ST_VERSION;
    if (cnt == 16'd0) return ST_NO_RECORDS;
    if (hdr_word(10, 2) != 32'(ENTRY_BYTES)) return ST_ENTRY_SIZE;
    if (rsz == 32'd0 || rsz[1:0] != 2'b00) return ST_RECORD_SIZE;
    if ((rsz >> 2) > 32'(MAX_FIELDS)) return ST_FIELDS;
    if (32'(cnt) > 32'(MAX_RECORDS)) return ST_RECORDS;
    if (index_span(cnt) > len) return ST_INDEX_END;
    return ST_OK;
  endfunction

  function automatic void forget_member();
    byte_at     = '0;
    slot        = '0;
    entry_idx   = '0;
    offset_acc  = '0;
    code_digits = 1'b1;
    index_top   = '0;
    settled     = 1'b0;
  endfunction

  function automatic void judge_byte(logic [7:0] b, logic [31:0] len, bit fin, bit typed,
                                     status_t want);
    verdict_t v;
    bit       emit;
    bit       hdr_ok;
    v      = '0;
    emit   = 1'b0;
    hdr_ok = 1'b0;
    live_bytes++;
    if (!settled) begin
      if (byte_at == 32'd0 && len < 32'(HEADER_BYTES)) begin
        v.status = ST_SHORT;
        emit     = 1'b1;
      end else if (byte_at < 32'(HEADER_BYTES)) begin
        hdr_store[byte_at[3:0]] = b;
        if (byte_at == 32'(HEADER_BYTES - 1)) begin
          hdr_ok   = 1'b1;
          v.status = header_verdict(len);
          if (v.status != ST_OK) emit = 1'b1;
          else index_top = index_span(16'(hdr_word(6, 2)));
        end
      end else begin
        hdr_ok = 1'b1;
        if (slot < CODE_LEN && (b < CH_ZERO || b > CH_NINE)) code_digits = 1'b0;
        if (slot >= OFF_FIRST && slot <= OFF_LAST)
          offset_acc = offset_acc | (32'(b) << (8 * (slot - OFF_FIRST)));
        if (slot == OFF_LAST) begin
          if (offset_acc < index_top || offset_acc > len ||
              hdr_word(12, 4) > len - offset_acc) begin
            v.status = ST_OFFSET;
            v.entry  = entry_idx;
            emit     = 1'b1;
          end else if (!code_digits) begin
            v.status = ST_CODE;
            v.entry  = entry_idx;
            emit     = 1'b1;
          end else if (32'(entry_idx) + 32'd1 >= hdr_word(6, 2)) begin
            v.status = ST_OK;
            emit     = 1'b1;
          end
        end
        if (32'(slot) + 32'd1 >= 32'(ENTRY_BYTES)) begin
          slot        = '0;
          entry_idx   = entry_idx + 16'd1;
          offset_acc  = '0;
          code_digits = 1'b1;
        end else begin
          slot = slot + 6'd1;
        end
      end
      if (!emit && fin) begin
        v.status = ST_TRUNCATED;
        emit     = 1'b1;
      end
      if (emit) begin
        if (hdr_ok) begin
          v.version = 16'(hdr_word(0, 2));
          v.date    = hdr_word(2, 4);
          v.count   = 16'(hdr_word(6, 2));
          v.fields  = 30'(hdr_word(12, 4) >> 2);
          v.region  = index_span(16'(hdr_word(6, 2)));
        end
        if (typed) v.status = want;
        verdicts_due.push_back(v);
        settled = 1'b1;
      end
      if (byte_at != '1) byte_at = byte_at + 32'd1;
    end
    if (fin) forget_member();
  endfunction

  function automatic void put_le(ref logic [7:0] q [$], input logic [31:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) q.push_back(8'(v >> (8 * i)));
  endfunction

  function automatic void make_member(input plan_t p, ref logic [7:0] q [$]);
    longint     span;
    longint     top;
    longint     off;
    int         n_ent;
    int         e;
    int         k;
    logic [7:0] c;
    q.delete();
    put_le(q, 32'(p.ver), 2);
    put_le(q, p.date, 4);
    put_le(q, 32'(p.cnt), 2);
    put_le(q, $urandom, 2);
    put_le(q, 32'(p.esz), 2);
    put_le(q, p.rsz, 4);
    span  = longint'(index_span(p.cnt));
    top   = longint'(p.len) - longint'(p.rsz);
    n_ent = (p.cnt < 16'd4) ? int'(p.cnt) : 4;
    for (e = 0; e < n_ent; e++) begin
      for (k = 0; k < CODE_LEN; k++) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if (p.flaw == FLAW_CODE && e == p.flaw_at) begin
        if ($urandom_range(0, 2) == 0) c = 8'h2F;
        else if ($urandom_range(0, 1) == 0) c = 8'h3A;
        else c = 8'h80 | 8'($urandom);
        q[q.size() - 1 - $urandom_range(0, CODE_LEN - 1)] = c;
      end
      q.push_back(8'($urandom));
      if (top >= span) off = span + longint'($urandom_range(0, 32'(top - span)));
      else off = longint'($urandom);
      if (e == p.flaw_at) begin
        case (p.flaw)
          FLAW_LOW:      off = span - 1;
          FLAW_NO_ROOM:  off = top + 1;
          FLAW_PAST_LEN: off = longint'(p.len) + 1;
          FLAW_TOP:      off = top;
          default:       ;
        endcase
      end
      put_le(q, 32'(off), 4);
    end
    if (p.cut > 0) while (q.size() > p.cut) void'(q.pop_back());
    repeat (p.extra) q.push_back(8'($urandom));
  endfunction

  function automatic plan_t random_plan();
    plan_t p;
    int    pick;
    p.ver     = 16'd1;
    p.date    = $urandom;
    p.cnt     = 16'($urandom_range(1, 4));
    p.esz     = 16'(ENTRY_BYTES);
    p.rsz     = 32'(4 * $urandom_range(1, MAX_FIELDS));
    if ($urandom_range(0, 1) == 0)
      p.len = index_span(p.cnt) + p.rsz * 32'(p.cnt) + 32'($urandom_range(0, 200));
    else
      p.len = $urandom | 32'h8000_0000;
    p.cut     = 0;
    p.flaw    = FLAW_NONE;
    p.flaw_at = $urandom_range(0, int'(p.cnt) - 1);
    p.extra   = 0;
    p.typed   = 1'b0;
    p.want    = ST_OK;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      p.flaw = flaw_t'($urandom_range(FLAW_LOW, FLAW_CODE));
    end else if (pick < 36) begin
      case ($urandom_range(0, 7))
        0: begin
          p.ver = 16'($urandom);
          if (p.ver == 16'd1) p.ver = 16'd2;
        end
        1: p.cnt = 16'd0;
        2: begin
          p.esz = 16'($urandom);
          if (p.esz == 16'(ENTRY_BYTES)) p.esz = 16'd12;
        end
        3: begin
          if ($urandom_range(0, 2) == 0) p.rsz = 32'd0;
          else p.rsz = ($urandom & 32'hFFFF_FFFC) | 32'($urandom_range(1, 3));
        end
        4: begin
          if ($urandom_range(0, 1) == 0) p.rsz = 32'(4 * $urandom_range(MAX_FIELDS + 1, 4096));
          else p.rsz = ($urandom & 32'hFFFF_FFFC) | 32'h0001_0000;
        end
        5: p.cnt = 16'($urandom_range(MAX_RECORDS + 1, 65535));
        6: p.len = $urandom_range(HEADER_BYTES, index_span(p.cnt) - 1);
        default: begin
          p.cnt = 16'($urandom_range(5, MAX_RECORDS));
          p.len = $urandom | 32'h8000_0000;
        end
      endcase
    end else if (pick < 44) begin
      p.cut = $urandom_range(1, HEADER_BYTES + int'(p.cnt) * ENTRY_BYTES - 1);
    end else if (pick < 48) begin
      p.len = $urandom_range(0, HEADER_BYTES - 1);
      p.cut = $urandom_range(1, 4);
    end else if (pick < 54) begin
      p.ver = 16'($urandom);
      p.cnt = 16'($urandom);
      p.esz = 16'($urandom);
      p.rsz = $urandom;
    end
    if ($urandom_range(0, 99) < 20) p.extra = $urandom_range(1, 6);
    return p;
  endfunction

  task automatic send_member(input plan_t p);
    logic [7:0] member_bytes [$];
    int         i;
    bit         last;
    make_member(p, member_bytes);
    for (i = 0; i < member_bytes.size(); i++) begin
      last = (i == member_bytes.size() - 1);
      while ($urandom_range(0, 99) < idle_pct) begin
        member_in.valid <= 1'b0;
        @(posedge clk);
      end
      member_in.valid         <= 1'b1;
      member_in.member_byte   <= member_bytes[i];
      member_in.member_length <= p.len;
      member_in.final_byte    <= last;
      do @(posedge clk); while (!member_in.ready);
      judge_byte(member_bytes[i], p.len, last, p.typed, p.want);
    end
  endtask

  function automatic void match(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    status_out.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    verdict_t due;
    if (rst_n && status_out.valid && status_out.ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: status expected none got %0d", $time, status_out.status);
        mismatches++;
      end else begin
        due = verdicts_due.pop_front();
        match("status", 32'(due.status), 32'(status_out.status));
        match("version_seen", 32'(due.version), 32'(status_out.version_seen));
        match("report_date_seen", due.date, status_out.report_date_seen);
        match("records_declared", 32'(due.count), 32'(status_out.records_declared));
        match("fields_per_record", 32'(due.fields), 32'(status_out.fields_per_record));
        match("data_region_start", due.region, status_out.data_region_start);
        match("failing_entry", 32'(due.entry), 32'(status_out.failing_entry));
      end
    end
  end

  initial begin
    int members;
    rst_n                   <= 1'b0;
    member_in.valid         <= 1'b0;
    member_in.member_byte   <= '0;
    member_in.member_length <= '0;
    member_in.final_byte    <= 1'b0;
    forget_member();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan_rows[r]) send_member(plan_rows[r]);
    members = 0;
    while (live_bytes < 800) begin
      // a stretch of members with both sides always ready
      idle_pct = (members >= 1 && members < 4) ? 0 : 23;
      send_member(random_plan());
      members++;
    end
    member_in.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
